// ----- hdl/gra_pkg.sv -----
// shared constants and codes for the guillotine rectangle allocator
`timescale 1ns / 1ps
package gra_pkg;
    localparam int FREE_SLOTS_DEF = 64;
    localparam int COORD_BITS_DEF = 15;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 15;
    localparam int RULE_BITS      = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BIN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BIN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHOICE     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPLIT      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MERGE      = 3'd4;

    localparam logic OP_INSERT    = 1'b0;
    localparam logic OP_RESET_BIN = 1'b1;

    localparam logic [RULE_BITS-1:0] CHOICE_BEST_AREA  = 3'd0;
    localparam logic [RULE_BITS-1:0] CHOICE_BEST_SHORT = 3'd1;
    localparam logic [RULE_BITS-1:0] CHOICE_BEST_LONG  = 3'd2;
    localparam logic [RULE_BITS-1:0] CHOICE_WORST_AREA = 3'd3;
    localparam logic [RULE_BITS-1:0] CHOICE_WORST_SHORT = 3'd4;
    localparam logic [RULE_BITS-1:0] CHOICE_WORST_LONG = 3'd5;

    localparam logic [RULE_BITS-1:0] SPLIT_SHORTER_LEFT = 3'd0;
    localparam logic [RULE_BITS-1:0] SPLIT_LONGER_LEFT  = 3'd1;
    localparam logic [RULE_BITS-1:0] SPLIT_MIN_AREA     = 3'd2;
    localparam logic [RULE_BITS-1:0] SPLIT_MAX_AREA     = 3'd3;
    localparam logic [RULE_BITS-1:0] SPLIT_SHORTER_AXIS = 3'd4;
    localparam logic [RULE_BITS-1:0] SPLIT_LONGER_AXIS  = 3'd5;
endpackage

// ----- hdl/gra_mem.sv -----
// free rectangle table: one write port, one registered read port
`timescale 1ns / 1ps
module gra_mem #(
    parameter int DEPTH = 64,
    parameter int DW    = 60
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- hdl/gra_score.sv -----
// choice rule score of one candidate, product difference and edge leftovers registered
`timescale 1ns / 1ps
module gra_score #(
    parameter int CB = 15
) (
    input  logic                   i_clk,
    input  logic                   i_load,
    input  logic [2:0]             i_rule,
    input  logic [CB-1:0]          i_fw,
    input  logic [CB-1:0]          i_fh,
    input  logic [CB-1:0]          i_pw,
    input  logic [CB-1:0]          i_ph,
    output logic signed [2*CB+1:0] o_score
);
    import gra_pkg::*;
    localparam int SW = 2 * CB + 2;

    logic [2*CB-1:0]      w_pf;
    logic [2*CB-1:0]      w_pp;
    logic signed [SW-1:0] r_area;
    logic [CB-1:0]        r_dx;
    logic [CB-1:0]        r_dy;
    logic signed [SW-1:0] w_short;
    logic signed [SW-1:0] w_long;

    assign w_pf = i_fw * i_fh;
    assign w_pp = i_pw * i_ph;

    // both leftovers are non-negative only when the candidate fits
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_area <= $signed({2'b00, w_pf}) - $signed({2'b00, w_pp});
            r_dx   <= i_fw - i_pw;
            r_dy   <= i_fh - i_ph;
        end
    end

    assign w_short = (r_dx < r_dy) ? $signed({{(SW-CB){1'b0}}, r_dx})
                                   : $signed({{(SW-CB){1'b0}}, r_dy});
    assign w_long  = (r_dx < r_dy) ? $signed({{(SW-CB){1'b0}}, r_dy})
                                   : $signed({{(SW-CB){1'b0}}, r_dx});

    always_comb begin
        case (i_rule)
            CHOICE_BEST_AREA:   o_score = r_area;
            CHOICE_BEST_SHORT:  o_score = w_short;
            CHOICE_BEST_LONG:   o_score = w_long;
            CHOICE_WORST_AREA:  o_score = -r_area;
            CHOICE_WORST_SHORT: o_score = -w_short;
            default:            o_score = -w_long;
        endcase
    end
endmodule

// ----- hdl/guillotine_rect_allocator.sv -----
// Work: reset_bin writes the bin as entry 0 and gives a result; insert reads and scores
// each free entry, then does the choice, split and pushes, then shifts entries down on removal,
// then with merging on visits each outer entry against each later one and shifts on each join,
// so the work is quadratic in the count; a stalled result waits in the output state.
// Throughput: one item at a time; the single read port of the free table sets the pace.
// Reset: table holds one zero rectangle, count one, state and config registers zero, no clearing pass.
`timescale 1ns / 1ps
module guillotine_rect_allocator #(
    parameter int FREE_SLOTS = gra_pkg::FREE_SLOTS_DEF,
    parameter int COORD_BITS = gra_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gra_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [gra_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_operation,
    input  logic [COORD_BITS-1:0]              i_req_width,
    input  logic [COORD_BITS-1:0]              i_req_height,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_placed,
    output logic [COORD_BITS-1:0]              o_pos_x,
    output logic [COORD_BITS-1:0]              o_pos_y,
    output logic [COORD_BITS-1:0]              o_out_width,
    output logic [COORD_BITS-1:0]              o_out_height,
    output logic                               o_rotated,
    output logic                               o_table_overflow
);
    import gra_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int AW = $clog2(FREE_SLOTS);
    localparam int CW = $clog2(FREE_SLOTS + 1);
    localparam int DW = 4 * CB;
    localparam int SW = 2 * CB + 2;
    localparam logic [CW-1:0] SLOTS = CW'(FREE_SLOTS);
    localparam logic [CW-1:0] ONE   = CW'(1);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_RST     = 5'd1;
    localparam logic [4:0] S_SCAN_RD = 5'd2;
    localparam logic [4:0] S_SCAN_C1 = 5'd3;
    localparam logic [4:0] S_SCAN_C2 = 5'd4;
    localparam logic [4:0] S_DONE    = 5'd5;
    localparam logic [4:0] S_SPLIT1  = 5'd6;
    localparam logic [4:0] S_SPLIT2  = 5'd7;
    localparam logic [4:0] S_PUSHA   = 5'd8;
    localparam logic [4:0] S_PUSHB   = 5'd9;
    localparam logic [4:0] S_SH_RD   = 5'd10;
    localparam logic [4:0] S_SH_WR   = 5'd11;
    localparam logic [4:0] S_M_IRD   = 5'd12;
    localparam logic [4:0] S_M_ILD   = 5'd13;
    localparam logic [4:0] S_M_JRD   = 5'd14;
    localparam logic [4:0] S_M_JCHK  = 5'd15;
    localparam logic [4:0] S_OUT     = 5'd16;

    logic [4:0]     r_state;
    logic [CB-1:0]  r_bin_w, r_bin_h;
    logic [2:0]     r_choice, r_split;
    logic           r_merge;
    logic [CW-1:0]  r_cnt, r_i, r_j, r_k;
    logic [AW-1:0]  r_best;
    logic           r_found, r_rot, r_ovf, r_ret_merge, r_e0_wr, r_rd_zero;
    logic [CB-1:0]  r_rw, r_rh, r_pw, r_ph;
    logic [DW-1:0]  r_brect, r_a, r_pa, r_pb;
    logic signed [SW-1:0] r_best_score;
    logic           r_cand_fit, r_cand_rot;
    logic [CB-1:0]  r_cand_pw, r_cand_ph;
    logic [DW-1:0]  r_cand_rect;
    logic [2*CB-1:0] r_p1, r_p2;

    logic           w_we;
    logic [AW-1:0]  w_waddr, w_raddr;
    logic [DW-1:0]  w_wdata, w_raw, w_rd;
    logic signed [SW-1:0] w_score;
    logic           w_out_free;

    gra_mem #(.DEPTH(FREE_SLOTS), .DW(DW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_raw)
    );

    // entry 0 reads as zero until first written after reset
    assign w_rd = r_rd_zero ? '0 : w_raw;

    logic [CB-1:0] f_x, f_y, f_w, f_h;
    assign f_x = w_rd[4*CB-1:3*CB];
    assign f_y = w_rd[3*CB-1:2*CB];
    assign f_w = w_rd[2*CB-1:CB];
    assign f_h = w_rd[CB-1:0];

    logic exact_u, exact_r, fit_u, fit_r;
    assign exact_u = (r_rw == f_w) && (r_rh == f_h);
    assign exact_r = (r_rh == f_w) && (r_rw == f_h);
    assign fit_u   = (r_rw <= f_w) && (r_rh <= f_h);
    assign fit_r   = (r_rh <= f_w) && (r_rw <= f_h);

    logic [CB-1:0] c_pw, c_ph;
    assign c_pw = fit_u ? r_rw : r_rh;
    assign c_ph = fit_u ? r_rh : r_rw;

    gra_score #(.CB(CB)) u_score (
        .i_clk   (i_clk),
        .i_load  (r_state == S_SCAN_C1),
        .i_rule  (r_choice),
        .i_fw    (f_w),
        .i_fh    (f_h),
        .i_pw    (c_pw),
        .i_ph    (c_ph),
        .o_score (w_score)
    );

    // chosen entry and split
    logic [CB-1:0] b_x, b_y, b_w, b_h, dw, dh;
    assign b_x = r_brect[4*CB-1:3*CB];
    assign b_y = r_brect[3*CB-1:2*CB];
    assign b_w = r_brect[2*CB-1:CB];
    assign b_h = r_brect[CB-1:0];
    assign dw  = b_w - r_pw;
    assign dh  = b_h - r_ph;

    logic w_horiz;
    always_comb begin
        case (r_split)
            SPLIT_SHORTER_LEFT: w_horiz = dw <= dh;
            SPLIT_LONGER_LEFT:  w_horiz = dw > dh;
            SPLIT_MIN_AREA:     w_horiz = r_p1 > r_p2;
            SPLIT_MAX_AREA:     w_horiz = r_p1 <= r_p2;
            SPLIT_SHORTER_AXIS: w_horiz = b_w <= b_h;
            SPLIT_LONGER_AXIS:  w_horiz = b_w > b_h;
            default:            w_horiz = 1'b1;
        endcase
    end

    logic pa_ok, pb_ok;
    assign pa_ok = (r_pa[2*CB-1:CB] != '0) && (r_pa[CB-1:0] != '0);
    assign pb_ok = (r_pb[2*CB-1:CB] != '0) && (r_pb[CB-1:0] != '0);

    // merge of held entry a with entry b
    logic [CB-1:0] a_x, a_y, a_w, a_h;
    assign a_x = r_a[4*CB-1:3*CB];
    assign a_y = r_a[3*CB-1:2*CB];
    assign a_w = r_a[2*CB-1:CB];
    assign a_h = r_a[CB-1:0];

    logic          joined;
    logic [DW-1:0] a_new;
    always_comb begin
        joined = 1'b0;
        a_new  = r_a;
        if ((a_w == f_w) && (a_x == f_x)) begin
            if ({1'b0, a_y} == ({1'b0, f_y} + {1'b0, f_h})) begin
                joined = 1'b1;
                a_new  = {a_x, CB'(a_y - f_h), a_w, CB'(a_h + f_h)};
            end else if (({1'b0, a_y} + {1'b0, a_h}) == {1'b0, f_y}) begin
                joined = 1'b1;
                a_new  = {a_x, a_y, a_w, CB'(a_h + f_h)};
            end
        end else if ((a_h == f_h) && (a_y == f_y)) begin
            if ({1'b0, a_x} == ({1'b0, f_x} + {1'b0, f_w})) begin
                joined = 1'b1;
                a_new  = {CB'(a_x - f_w), a_y, CB'(a_w + f_w), a_h};
            end else if (({1'b0, a_x} + {1'b0, a_w}) == {1'b0, f_x}) begin
                joined = 1'b1;
                a_new  = {a_x, a_y, CB'(a_w + f_w), a_h};
            end
        end
    end

    logic [CW-1:0] k_next;
    assign k_next = r_k + ONE;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt[AW-1:0];
        w_wdata = r_pa;
        w_raddr = r_i[AW-1:0];
        case (r_state)
            S_RST: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = {{(2*CB){1'b0}}, r_bin_w, r_bin_h};
            end
            S_PUSHA: begin
                w_we    = pa_ok && (r_cnt < SLOTS);
                w_wdata = r_pa;
            end
            S_PUSHB: begin
                w_we    = pb_ok && (r_cnt < SLOTS);
                w_wdata = r_pb;
            end
            S_SH_RD:  w_raddr = k_next[AW-1:0];
            S_SH_WR: begin
                w_we    = 1'b1;
                w_waddr = r_k[AW-1:0];
                w_wdata = w_rd;
            end
            S_M_JRD:  w_raddr = r_j[AW-1:0];
            S_M_JCHK: begin
                w_we    = joined;
                w_waddr = r_i[AW-1:0];
                w_wdata = a_new;
            end
            default: ;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_free = !o_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        r_rd_zero <= (w_raddr == '0) && !r_e0_wr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= ONE;
            r_e0_wr     <= 1'b0;
            r_bin_w     <= '0;
            r_bin_h     <= '0;
            r_choice    <= '0;
            r_split     <= '0;
            r_merge     <= 1'b0;
            o_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_ovf       <= 1'b0;
            r_ret_merge <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            if (w_we && (w_waddr == '0)) begin
                r_e0_wr <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BIN_WIDTH:  r_bin_w  <= i_cfg_data[CB-1:0];
                    CFG_BIN_HEIGHT: r_bin_h  <= i_cfg_data[CB-1:0];
                    CFG_CHOICE:     r_choice <= i_cfg_data[2:0];
                    CFG_SPLIT:      r_split  <= i_cfg_data[2:0];
                    CFG_MERGE:      r_merge  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_rw    <= i_req_width;
                        r_rh    <= i_req_height;
                        r_found <= 1'b0;
                        r_ovf   <= 1'b0;
                        r_i     <= '0;
                        if (i_operation == OP_RESET_BIN) begin
                            r_state <= S_RST;
                        end else if (r_cnt == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                S_RST: begin
                    r_cnt   <= ONE;
                    r_state <= S_OUT;
                end
                S_SCAN_RD: r_state <= S_SCAN_C1;
                S_SCAN_C1: begin
                    if (exact_u || exact_r) begin
                        r_best  <= r_i[AW-1:0];
                        r_pw    <= exact_u ? r_rw : r_rh;
                        r_ph    <= exact_u ? r_rh : r_rw;
                        r_rot   <= !exact_u;
                        r_found <= 1'b1;
                        r_brect <= w_rd;
                        r_state <= S_DONE;
                    end else begin
                        r_cand_fit  <= (fit_u || fit_r) && (r_choice <= CHOICE_WORST_LONG);
                        r_cand_rot  <= !fit_u;
                        r_cand_pw   <= c_pw;
                        r_cand_ph   <= c_ph;
                        r_cand_rect <= w_rd;
                        r_state     <= S_SCAN_C2;
                    end
                end
                S_SCAN_C2: begin
                    if (r_cand_fit && (!r_found || (w_score < r_best_score))) begin
                        r_best       <= r_i[AW-1:0];
                        r_pw         <= r_cand_pw;
                        r_ph         <= r_cand_ph;
                        r_rot        <= r_cand_rot;
                        r_found      <= 1'b1;
                        r_brect      <= r_cand_rect;
                        r_best_score <= w_score;
                    end
                    r_i     <= r_i + ONE;
                    r_state <= ((r_i + ONE) < r_cnt) ? S_SCAN_RD : S_DONE;
                end
                S_DONE: begin
                    r_state <= (r_found && (r_ph != '0)) ? S_SPLIT1 : S_OUT;
                end
                S_SPLIT1: begin
                    r_p1    <= r_pw * dh;
                    r_p2    <= dw * r_ph;
                    r_state <= S_SPLIT2;
                end
                S_SPLIT2: begin
                    r_pa    <= {b_x, CB'(b_y + r_ph), (w_horiz ? b_w : r_pw), dh};
                    r_pb    <= {CB'(b_x + r_pw), b_y, dw, (w_horiz ? r_ph : b_h)};
                    r_state <= S_PUSHA;
                end
                S_PUSHA, S_PUSHB: begin
                    if ((r_state == S_PUSHA) ? pa_ok : pb_ok) begin
                        if (r_cnt >= SLOTS) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_cnt <= r_cnt + ONE;
                        end
                    end
                    if (r_state == S_PUSHA) begin
                        r_state <= S_PUSHB;
                    end else begin
                        r_k         <= CW'(r_best);
                        r_ret_merge <= 1'b0;
                        r_state     <= S_SH_RD;
                    end
                end
                S_SH_RD: begin
                    if (k_next < r_cnt) begin
                        r_state <= S_SH_WR;
                    end else begin
                        r_cnt <= r_cnt - ONE;
                        if (r_ret_merge) begin
                            r_state <= S_M_JRD;
                        end else if (r_merge) begin
                            r_i     <= '0;
                            r_state <= S_M_IRD;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_SH_WR: begin
                    r_k     <= k_next;
                    r_state <= S_SH_RD;
                end
                S_M_IRD: r_state <= (r_i < r_cnt) ? S_M_ILD : S_OUT;
                S_M_ILD: begin
                    r_a     <= w_rd;
                    r_j     <= r_i + ONE;
                    r_state <= S_M_JRD;
                end
                S_M_JRD: begin
                    if (r_j < r_cnt) begin
                        r_state <= S_M_JCHK;
                    end else begin
                        r_i     <= r_i + ONE;
                        r_state <= S_M_IRD;
                    end
                end
                S_M_JCHK: begin
                    if (joined) begin
                        r_a         <= a_new;
                        r_k         <= r_j;
                        r_ret_merge <= 1'b1;
                        r_state     <= S_SH_RD;
                    end else begin
                        r_j     <= r_j + ONE;
                        r_state <= S_M_JRD;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        o_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result payload, loaded with the valid flag
    logic w_pl;
    assign w_pl = r_found && (r_ph != '0);

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            o_placed         <= w_pl;
            o_pos_x          <= w_pl ? b_x : '0;
            o_pos_y          <= w_pl ? b_y : '0;
            o_out_width      <= w_pl ? r_pw : '0;
            o_out_height     <= w_pl ? r_ph : '0;
            o_rotated        <= w_pl && r_rot;
            o_table_overflow <= w_pl && r_ovf;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= SLOTS) else $error("free count above table depth");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall) else $error("accepted item not held");
    a_unplaced_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_placed) |-> (o_pos_x == '0 && o_pos_y == '0 &&
        o_out_width == '0 && o_out_height == '0 && !o_rotated && !o_table_overflow))
        else $error("unplaced result carries data");
    a_placed_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_placed) |-> (o_out_height != '0))
        else $error("placed result with zero height");
`endif
endmodule
